// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL file of the texture decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/ptud_pkg.sv =====
// Types, codes and helper functions of the paletted texture unswizzle decoder.
package ptud_pkg;

    localparam int SIDE_W      = 9;
    localparam int TEX_WORD_AW = 16;
    localparam int TEX_WORDS   = 1 << TEX_WORD_AW;
    localparam int PAL_AW      = 8;
    localparam int PAL_ENTRIES = 1 << PAL_AW;
    localparam int COUNT_W     = 17;
    localparam int TOTAL_W     = 2 * SIDE_W;
    localparam int PROD_W      = 24;

    localparam logic [1:0] FUNC_TEX_WR = 2'd0;
    localparam logic [1:0] FUNC_PAL_WR = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_REPORT = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DEPTH  = 2'd2;

    localparam logic [1:0] MODE_4BIT = 2'd0;
    localparam logic [1:0] MODE_8BIT = 2'd1;
    localparam int         MODE_RGBA_BIT = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [7:0] ALPHA_CLEAR_MAX   = 8'd8;
    localparam logic [7:0] ALPHA_PARTIAL_LIM = 8'd248;
    localparam logic [7:0] ALPHA_SAT         = 8'd255;
    localparam logic [7:0] SWAP_KEEP_MASK    = 8'hE7;
    localparam logic [2:0] SEL_STEP          = 3'h4;
    localparam logic [PROD_W-1:0] PCT_SCALE  = 24'd100;
    localparam logic [PROD_W-1:0] GRAD_PCT   = 24'd15;
    localparam logic [PROD_W-1:0] CLEAR_PCT  = 24'd2;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } rgba_t;

    function automatic logic [7:0] swap_bits34(input logic [7:0] i);
        return (i & SWAP_KEEP_MASK) | {3'b000, i[3], i[4], 3'b000};
    endfunction

    function automatic logic [7:0] double_alpha(input logic [7:0] a);
        return a[7] ? ALPHA_SAT : {a[6:0], 1'b0};
    endfunction

endpackage

// ===== hdl/paletted_texture_unswizzle_decoder.sv =====
// Paletted texture decoder: texel and palette memories, unswizzle, lookup, alpha stats.
//
// Software loads raw swizzled texel bytes (func 0) and palette entries (func 1); each write
// gives no result. A pixel read (func 2) computes the unswizzled or linear address with
// one row-by-width multiply, reads the 64K x 32 texel memory, then for the paletted
// modes reads the 256 x 32 palette memory with the index taken from the texel. Items,
// reads and reports (func 3) alike, are taken one at a time: the next is accepted only once
// the dependent memory reads of the last are done and its result is in the output register.
// Results sit in an output register, so the next item is taken while one waits.
// Alpha is doubled and saturated; reads of never written entries return undefined data.
`include "assert_macros.svh"

module paletted_texture_unswizzle_decoder
    import ptud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // texel_address[17:0], texel_byte[25:18], palette_slot[33:26],
    // palette_color[65:34], pixel_x[73:66], pixel_y[81:74], zero pad
    input  logic [87:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24],
    // has_alpha_gradient[32], has_transparent_texels[33], zero pad
    output logic [39:0] m_axis_tdata,
    // result_kind[0]
    output logic        m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TEX  = 2'd1;
    localparam logic [1:0] S_PAL  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SIDE_W-1:0] width_reg, height_reg;
    logic [1:0]        depth_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [COUNT_W-1:0] partial_cnt_reg, clear_cnt_reg;

    logic [1:0]  lane_reg;
    logic        nib_reg;
    logic        pend_kind_reg;
    rgba_t       pend_rgba_reg;
    logic        pend_grad_reg, pend_clear_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    rgba_t       out_rgba_reg;
    logic        out_grad_reg, out_clear_reg;

    logic [31:0] tex_q;
    logic [31:0] pal_q;
    logic [3:0][7:0] tex_mem [TEX_WORDS];
    logic [31:0] pal_mem [PAL_ENTRIES];

    logic [1:0]  func;
    logic [17:0] texel_address;
    logic [7:0]  texel_byte, palette_slot, pixel_x, pixel_y;
    logic [31:0] palette_color;

    assign func          = s_axis_tuser;
    assign texel_address = s_axis_tdata[17:0];
    assign texel_byte    = s_axis_tdata[25:18];
    assign palette_slot  = s_axis_tdata[33:26];
    assign palette_color = s_axis_tdata[65:34];
    assign pixel_x       = s_axis_tdata[73:66];
    assign pixel_y       = s_axis_tdata[81:74];

    logic in_acc, mode_rgba, out_free;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign mode_rgba     = depth_reg[MODE_RGBA_BIT];
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    // address generation
    logic [2:0]  posy, xs;
    logic        sel;
    logic [7:0]  mrow;
    logic [16:0] prod, uaddr, laddr;
    logic [TEX_WORD_AW-1:0] rd_word;
    logic [1:0]  rd_lane;

    always_comb
    begin
        posy  = {pixel_y[3:2], pixel_y[0]};
        sel   = pixel_y[2] ^ pixel_y[1];
        xs    = pixel_x[2:0] + (sel ? SEL_STEP : 3'd0);
        mrow  = mode_rgba ? pixel_y : {pixel_y[7:4], posy, 1'b0};
        prod  = {9'd0, mrow} * {8'd0, width_reg};
        uaddr = prod + {8'd0, pixel_x[7:4], xs, pixel_x[3], pixel_y[1]};
        laddr = prod + {9'd0, pixel_x};
        if (mode_rgba)
        begin
            rd_word = laddr[TEX_WORD_AW-1:0];
            rd_lane = 2'd0;
        end
        else if (depth_reg == MODE_8BIT)
        begin
            rd_word = {1'b0, uaddr[16:2]};
            rd_lane = uaddr[1:0];
        end
        else
        begin
            rd_word = {2'b00, uaddr[16:3]};
            rd_lane = uaddr[2:1];
        end
    end

    logic tex_we, tex_re, pal_we, pal_re;
    assign tex_we = in_acc && (func == FUNC_TEX_WR);
    assign tex_re = in_acc && (func == FUNC_READ);
    assign pal_we = in_acc && (func == FUNC_PAL_WR);
    assign pal_re = (state_reg == S_TEX) && !mode_rgba;

    always_ff @(posedge clk)
    begin
        if (tex_we)
        begin
            tex_mem[texel_address[17:2]][texel_address[1:0]] <= texel_byte;
        end
        if (tex_re)
        begin
            tex_q <= tex_mem[rd_word];
        end
    end

    // palette index from the fetched texel byte
    logic [7:0] tbyte, pidx;
    always_comb
    begin
        tbyte = tex_q[{lane_reg, 3'b000} +: 8];
        if (depth_reg == MODE_4BIT)
        begin
            pidx = nib_reg ? {4'd0, tbyte[7:4]} : {4'd0, tbyte[3:0]};
        end
        else
        begin
            pidx = swap_bits34(tbyte);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[palette_slot] <= palette_color;
        end
        if (pal_re)
        begin
            pal_q <= pal_mem[pidx];
        end
    end

    // pixel finish and report flags
    logic       pix_done;
    rgba_t      pix;
    logic [7:0] dbl;
    logic       is_partial, is_clear;
    logic [PROD_W-1:0] part_scaled, clear_scaled, tot_grad, tot_clear;
    logic       grad_flag, clear_flag;

    always_comb
    begin
        pix_done   = ((state_reg == S_TEX) && mode_rgba) || (state_reg == S_PAL);
        pix        = (state_reg == S_PAL) ? rgba_t'(pal_q) : rgba_t'(tex_q);
        dbl        = double_alpha(pix.a);
        is_clear   = (dbl <= ALPHA_CLEAR_MAX);
        is_partial = !is_clear && (dbl < ALPHA_PARTIAL_LIM);
        part_scaled  = PROD_W'(partial_cnt_reg) * PCT_SCALE;
        clear_scaled = PROD_W'(clear_cnt_reg) * PCT_SCALE;
        tot_grad     = PROD_W'(total_reg) * GRAD_PCT;
        tot_clear    = PROD_W'(total_reg) * CLEAR_PCT;
        grad_flag  = (total_reg != '0) && (part_scaled >= tot_grad);
        clear_flag = (total_reg != '0) && (clear_scaled >= tot_clear);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (func == FUNC_READ))
                begin
                    state_next = S_TEX;
                end
                else if (in_acc && (func == FUNC_REPORT))
                begin
                    state_next = S_OUT;
                end
            end
            S_TEX:
            begin
                state_next = mode_rgba ? S_OUT : S_PAL;
            end
            S_PAL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            width_reg       <= 9'd256;
            height_reg      <= 9'd256;
            depth_reg       <= MODE_8BIT;
            total_reg       <= 18'd65536;
            partial_cnt_reg <= '0;
            clear_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_WIDTH:
                    begin
                        width_reg <= cfg_data;
                        total_reg <= {9'd0, cfg_data} * {9'd0, height_reg};
                    end
                    CFG_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                        total_reg  <= {9'd0, width_reg} * {9'd0, cfg_data};
                    end
                    CFG_DEPTH:  depth_reg  <= cfg_data[1:0];
                    default:    ;
                endcase
            end
            if (in_acc && (func == FUNC_REPORT))
            begin
                partial_cnt_reg <= '0;
                clear_cnt_reg   <= '0;
            end
            else if (pix_done)
            begin
                if (is_partial && (partial_cnt_reg != COUNT_MAX))
                begin
                    partial_cnt_reg <= partial_cnt_reg + COUNT_W'(1);
                end
                if (is_clear && (clear_cnt_reg != COUNT_MAX))
                begin
                    clear_cnt_reg <= clear_cnt_reg + COUNT_W'(1);
                end
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tex_re)
        begin
            lane_reg <= rd_lane;
            nib_reg  <= uaddr[0];
        end
        if (in_acc && (func == FUNC_REPORT))
        begin
            pend_kind_reg  <= 1'b1;
            pend_rgba_reg  <= '0;
            pend_grad_reg  <= grad_flag;
            pend_clear_reg <= clear_flag;
        end
        else if (pix_done)
        begin
            pend_kind_reg  <= 1'b0;
            pend_rgba_reg  <= '{a: dbl, b: pix.b, g: pix.g, r: pix.r};
            pend_grad_reg  <= 1'b0;
            pend_clear_reg <= 1'b0;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            out_kind_reg  <= pend_kind_reg;
            out_rgba_reg  <= pend_rgba_reg;
            out_grad_reg  <= pend_grad_reg;
            out_clear_reg <= pend_clear_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {6'd0, out_clear_reg, out_grad_reg, out_rgba_reg};

    `ASSERT_NEXT(a_report_clears, clk, rst_n, in_acc && (func == FUNC_REPORT),
        (partial_cnt_reg == '0) && (clear_cnt_reg == '0),
        "report did not clear the alpha counters")
    `ASSERT_NEXT(a_counts_hold, clk, rst_n, !(in_acc && (func == FUNC_REPORT)),
        (partial_cnt_reg >= $past(partial_cnt_reg)) && (clear_cnt_reg >= $past(clear_cnt_reg)),
        "alpha counter dropped without a report")
    `ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_reg == S_OUT) && out_free,
        m_axis_tvalid && (state_reg == S_IDLE),
        "finished result not moved to the output register")

endmodule

// ===== sim/paletted_texture_unswizzle_decoder_tb.sv =====
// Self-checking testbench of the paletted texture unswizzle decoder, with its own decode model.
`timescale 1ns / 100ps

module paletted_texture_unswizzle_decoder_tb
    import ptud_pkg::*;
();

    localparam int          RESET_CYCLES   = 11;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          ALPHA_REPEATS  = 20;
    localparam int unsigned ADDR_MASK      = 32'h3FFFF;
    localparam int unsigned CNT_SAT        = 131071;
    localparam int unsigned ALPHA_TOP      = 255;
    localparam int unsigned CLEAR_TOP      = 8;
    localparam int unsigned OPAQUE_FLOOR   = 248;
    localparam logic [1:0]  MODE_RGBA      = 2'd2;
    localparam logic [1:0]  MODE_RGBA_ALT  = 2'd3;

    typedef struct packed {
        bit [5:0]  pad;
        bit [7:0]  y;
        bit [7:0]  x;
        bit [31:0] color;
        bit [7:0]  slot;
        bit [7:0]  tbyte;
        bit [17:0] taddr;
    } tex_item_t;

    typedef struct {
        bit       kind;
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit [7:0] alpha;
        bit       grad;
        bit       clear;
    } pixel_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // texel_address[17:0], texel_byte[25:18], palette_slot[33:26],
    // palette_color[65:34], pixel_x[73:66], pixel_y[81:74], zero pad
    logic [87:0] s_axis_tdata;
    // func[1:0]
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // red[7:0], green[15:8], blue[23:16], alpha[31:24],
    // has_alpha_gradient[32], has_transparent_texels[33], zero pad
    logic [39:0] m_axis_tdata;
    // result_kind[0]
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    // decode model state
    bit [7:0]    tex_mem[int unsigned];
    bit [31:0]   pal_mem[int unsigned];
    bit [8:0]    cfg_width   = 9'd256;
    bit [8:0]    cfg_height  = 9'd256;
    bit [1:0]    cfg_mode    = MODE_8BIT;
    int unsigned partial_cnt = 0;
    int unsigned clear_cnt   = 0;
    pixel_out_t  decoded_fifo[$];

    int          mismatch_count = 0;
    int          src_idle_pct   = 0;
    int          snk_idle_pct   = 0;
    int          hold_requests  = 0;

    paletted_texture_unswizzle_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- address and decode model ----------------

    function automatic int unsigned swz_addr(input bit [7:0] x, input bit [7:0] y);
        int unsigned xx = x;
        int unsigned yy = y;
        int unsigned ww = cfg_width;
        int unsigned sel;
        int unsigned posy;
        int unsigned bsel;
        sel  = (((yy + 2) >> 2) & 1) * 4;
        posy = (((yy & ~32'd3) >> 1) + (yy & 1)) & 7;
        bsel = ((yy >> 1) & 1) + ((xx >> 2) & 2);
        return (yy & ~32'd15) * ww + (xx & ~32'd15) * 2 + posy * ww * 2
               + ((xx + sel) & 7) * 4 + bsel;
    endfunction

    function automatic int unsigned linear_base(input bit [7:0] x, input bit [7:0] y);
        int unsigned xx = x;
        int unsigned yy = y;
        int unsigned ww = cfg_width;
        return (yy * ww + xx) * 4;
    endfunction

    function automatic int unsigned pal_byte_addr(input bit [7:0] x, input bit [7:0] y);
        if (cfg_mode == MODE_8BIT)
            return swz_addr(x, y) & ADDR_MASK;
        return (swz_addr(x, y) >> 1) & ADDR_MASK;
    endfunction

    function automatic bit [7:0] pal_index_of(input bit [7:0] x, input bit [7:0] y);
        bit [7:0]    raw;
        int unsigned u;
        raw = tex_mem[pal_byte_addr(x, y)];
        u   = swz_addr(x, y);
        if (cfg_mode == MODE_8BIT)
            return {raw[7:5], raw[3], raw[4], raw[2:0]};
        return u[0] ? {4'h0, raw[7:4]} : {4'h0, raw[3:0]};
    endfunction

    function automatic void decode_item(input logic [1:0] f, input tex_item_t it);
        pixel_out_t      res;
        int unsigned     base;
        int unsigned     alpha2;
        bit [31:0]       colr;
        longint unsigned area;
        res = '{default: 0};
        case (f)
            FUNC_TEX_WR:
                tex_mem[it.taddr] = it.tbyte;
            FUNC_PAL_WR:
                pal_mem[it.slot] = it.color;
            FUNC_REPORT:
            begin
                area       = longint'(cfg_width) * longint'(cfg_height);
                res.kind   = 1'b1;
                res.grad   = (area != 0) && (longint'(partial_cnt) * 100 >= 15 * area);
                res.clear  = (area != 0) && (longint'(clear_cnt) * 100 >= 2 * area);
                partial_cnt = 0;
                clear_cnt   = 0;
                decoded_fifo.insert(decoded_fifo.size(), res);
            end
            FUNC_READ:
            begin
                if (cfg_mode[MODE_RGBA_BIT])
                begin
                    base = linear_base(it.x, it.y);
                    colr = {tex_mem[(base + 3) & ADDR_MASK], tex_mem[(base + 2) & ADDR_MASK],
                            tex_mem[(base + 1) & ADDR_MASK], tex_mem[base & ADDR_MASK]};
                end
                else
                    colr = pal_mem[pal_index_of(it.x, it.y)];
                alpha2 = 2 * int'(colr[31:24]);
                if (alpha2 > ALPHA_TOP)
                    alpha2 = ALPHA_TOP;
                if (alpha2 > CLEAR_TOP && alpha2 < OPAQUE_FLOOR && partial_cnt < CNT_SAT)
                    partial_cnt++;
                if (alpha2 <= CLEAR_TOP && clear_cnt < CNT_SAT)
                    clear_cnt++;
                res.red   = colr[7:0];
                res.green = colr[15:8];
                res.blue  = colr[23:16];
                res.alpha = alpha2[7:0];
                decoded_fifo.insert(decoded_fifo.size(), res);
            end
        endcase
    endfunction

    // ---------------- random helpers ----------------

    // skewed toward alphas that double into the clear and the opaque classes
    function automatic bit [7:0] rand_byte();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(4));
            1:       return 8'($urandom_range(124, 255));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic bit [31:0] rand_color();
        return {rand_byte(), 24'($urandom_range(24'hFFFFFF))};
    endfunction

    function automatic bit [7:0] rand_coord(input bit [8:0] limit);
        if (limit != 0 && limit <= 256 && $urandom_range(3) != 0)
            return 8'($urandom_range(limit - 1));
        return 8'($urandom_range(255));
    endfunction

    function automatic tex_item_t noise_item();
        tex_item_t it;
        it.pad   = '0;
        it.y     = 8'($urandom_range(255));
        it.x     = 8'($urandom_range(255));
        it.color = $urandom;
        it.slot  = 8'($urandom_range(255));
        it.tbyte = 8'($urandom_range(255));
        it.taddr = 18'($urandom_range(ADDR_MASK));
        return it;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_beat(input logic [1:0] f, input tex_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tuser  = f;
        s_axis_tdata  = it;
        s_axis_tvalid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        decode_item(f, it);
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid = 1'b0;
        while (decoded_fifo.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input int unsigned val);
        drain_pipeline();
        cfg_index = idx;
        cfg_data  = val[8:0];
        cfg_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            CFG_WIDTH:  cfg_width  = val[8:0];
            CFG_HEIGHT: cfg_height = val[8:0];
            CFG_DEPTH:  cfg_mode   = val[1:0];
            default:    ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_texel(input bit [17:0] addr, input bit [7:0] val);
        tex_item_t it;
        it       = noise_item();
        it.taddr = addr;
        it.tbyte = val;
        send_beat(FUNC_TEX_WR, it);
    endtask

    task automatic write_palette(input bit [7:0] slot, input bit [31:0] color);
        tex_item_t it;
        it       = noise_item();
        it.slot  = slot;
        it.color = color;
        send_beat(FUNC_PAL_WR, it);
    endtask

    task automatic ensure_texel(input int unsigned addr);
        if (!tex_mem.exists(addr & ADDR_MASK))
            write_texel(18'(addr & ADDR_MASK), rand_byte());
    endtask

    // fills whatever the read will touch first, so no unwritten entry is ever read
    task automatic read_pixel(input bit [7:0] x, input bit [7:0] y);
        tex_item_t it;
        int        k;
        if (cfg_mode[MODE_RGBA_BIT])
        begin
            for (k = 0; k < 4; k++)
                ensure_texel(linear_base(x, y) + k);
        end
        else
        begin
            ensure_texel(pal_byte_addr(x, y));
            if (!pal_mem.exists(pal_index_of(x, y)))
                write_palette(pal_index_of(x, y), rand_color());
        end
        it   = noise_item();
        it.x = x;
        it.y = y;
        send_beat(FUNC_READ, it);
    endtask

    task automatic request_report();
        send_beat(FUNC_REPORT, noise_item());
    endtask

    task automatic random_config();
        int unsigned w;
        int unsigned h;
        case ($urandom_range(5))
            0:       w = 16;
            1:       w = 256;
            2:       w = $urandom_range(511);
            default: w = $urandom_range(16, 256);
        endcase
        case ($urandom_range(5))
            0:       h = 1;
            1:       h = 256;
            2:       h = $urandom_range(511);
            default: h = $urandom_range(1, 64);
        endcase
        write_cfg(CFG_WIDTH, w);
        write_cfg(CFG_HEIGHT, h);
        write_cfg(CFG_DEPTH, $urandom_range(3));
    endtask

    // ---------------- receiver and checker ----------------

    initial
    begin : sink_proc
        int hold_left;
        int hold_seen;
        hold_left     = 0;
        hold_seen     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
                m_axis_tready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task automatic check_result();
        pixel_out_t want;
        if (decoded_fifo.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected beat, kind %0d data %h",
                                    m_axis_tuser, m_axis_tdata));
            return;
        end
        want = decoded_fifo.pop_front();
        compare_field("result_kind", m_axis_tuser, want.kind);
        compare_field("red", m_axis_tdata[7:0], want.red);
        compare_field("green", m_axis_tdata[15:8], want.green);
        compare_field("blue", m_axis_tdata[23:16], want.blue);
        compare_field("alpha", m_axis_tdata[31:24], want.alpha);
        compare_field("has_alpha_gradient", m_axis_tdata[32], want.grad);
        compare_field("has_transparent_texels", m_axis_tdata[33], want.clear);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat accepted in %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------- tests ----------------

    task automatic test_directed();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        // reset config: 256 x 256, 8-bit paletted
        write_palette(8'h00, 32'h0000_0000);
        write_palette(8'hFF, 32'hFFFF_FFFF);
        write_texel(18'h00000, 8'h00);
        write_texel(18'h3FFFF, 8'hFF);
        read_pixel(8'd0, 8'd0);
        read_pixel(8'd255, 8'd255);
        write_texel(18'(pal_byte_addr(8'd1, 8'd0)), 8'h08);   // index lands on entry 0x10
        read_pixel(8'd1, 8'd0);
        request_report();
        write_cfg(CFG_DEPTH, MODE_4BIT);
        read_pixel(8'd0, 8'd0);                           // low nibble
        read_pixel(8'd0, 8'd2);                           // high nibble
        read_pixel(8'd255, 8'd255);
        write_cfg(CFG_DEPTH, MODE_RGBA);
        read_pixel(8'd0, 8'd0);
        read_pixel(8'd255, 8'd255);
        write_cfg(CFG_DEPTH, MODE_RGBA_ALT);
        read_pixel(8'd7, 8'd3);
        write_cfg(CFG_WIDTH, 0);
        write_cfg(CFG_HEIGHT, 0);
        read_pixel(8'd5, 8'd5);
        request_report();                                 // zero area
        write_cfg(CFG_WIDTH, 511);
        write_cfg(CFG_HEIGHT, 511);
        read_pixel(8'd255, 8'd255);                       // address wraps
        request_report();
        write_cfg(CFG_WIDTH, 16);
        write_cfg(CFG_HEIGHT, 1);
        write_cfg(CFG_DEPTH, MODE_8BIT);
        read_pixel(8'd15, 8'd0);
        request_report();
    endtask

    task automatic test_random_traffic(input int n_items, input int src_pct, input int snk_pct);
        int       i;
        int       pick;
        bit [7:0] x;
        bit [7:0] y;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        random_config();
        for (i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                read_pixel(rand_coord(cfg_width), rand_coord(cfg_height));
            else if (pick < 65)
                write_texel(18'($urandom_range(ADDR_MASK)), rand_byte());
            else if (pick < 75)
            begin
                x = rand_coord(cfg_width);
                y = rand_coord(cfg_height);
                if (cfg_mode[MODE_RGBA_BIT])
                    write_texel(18'((linear_base(x, y) + $urandom_range(3)) & ADDR_MASK),
                                rand_byte());
                else
                    write_texel(18'(pal_byte_addr(x, y)), 8'($urandom_range(255)));
                read_pixel(x, y);
            end
            else if (pick < 85)
                write_palette(8'($urandom_range(255)), rand_color());
            else if (pick < 95)
                request_report();
            else
                random_config();
        end
    endtask

    task automatic test_backpressure();
        int i;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_requests++;
        for (i = 0; i < 30; i++)
            read_pixel(rand_coord(cfg_width), rand_coord(cfg_height));
    endtask

    // partial and clear alphas on a tiny raster, so both report flags rise
    task automatic test_alpha_classes();
        int i;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_cfg(CFG_WIDTH, 16);
        write_cfg(CFG_HEIGHT, 1);
        write_cfg(CFG_DEPTH, MODE_RGBA);
        write_texel(18'd3, 8'h40);                        // pixel (0,0): partial
        write_texel(18'd7, 8'h00);                        // pixel (1,0): clear
        read_pixel(8'd0, 8'd0);
        read_pixel(8'd1, 8'd0);
        request_report();
        for (i = 0; i < ALPHA_REPEATS; i++)
        begin
            read_pixel(8'd0, 8'd0);
            read_pixel(8'd1, 8'd0);
        end
        request_report();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_TEX_WR;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_WIDTH;
        cfg_data      = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_traffic(140, 12, 72);
        test_random_traffic(140, 72, 12);
        test_random_traffic(140, 0, 0);
        test_backpressure();
        test_alpha_classes();
        drain_pipeline();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ptud_pkg.sv
hdl/paletted_texture_unswizzle_decoder.sv
sim/paletted_texture_unswizzle_decoder_tb.sv
